/* sv/tctb_pkg.sv */
// Shared types, constants and the microcode table of the countdown timer bank.
// Used by tctb_seq and tagged_countdown_timer_bank; depends on nothing.
`default_nettype none

package tctb_pkg;

    localparam int SLOTS  = 8;
    localparam int IDX_W  = $clog2(SLOTS);
    localparam int CNT_W  = $clog2(SLOTS + 1);
    localparam int TAG_W  = 16;
    localparam int SEC_W  = 16;
    localparam int CMD_W  = 2;
    localparam int KIND_W = 3;
    localparam int CAP_W  = 4;

    localparam logic [CMD_W-1:0] CMD_SET  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_TICK = 2'd1;
    localparam logic [CMD_W-1:0] CMD_LIST = 2'd2;

    typedef enum logic [KIND_W-1:0] {
        KIND_CREATED = 3'd0,
        KIND_UPDATED = 3'd1,
        KIND_FULL    = 3'd2,
        KIND_EXPIRED = 3'd3,
        KIND_ENTRY   = 3'd4,
        KIND_EMPTY   = 3'd5
    } kind_t;

    // microprogram addresses
    typedef enum logic [4:0] {
        ST_IDLE, ST_DSP0, ST_DSP1, ST_DSP2,
        ST_SSCAN, ST_SCMP, ST_SNEXT, ST_SUPD, ST_SCAP, ST_SNEW, ST_SCRE, ST_SFULL,
        ST_TCNT, ST_TPREP, ST_TWALK, ST_TSLOT, ST_TKEEP, ST_TEXP, ST_TFIN,
        ST_LCHK, ST_LEMPTY, ST_LENT, ST_LNXT
    } step_t;

    typedef enum logic [3:0] {
        C_ALWAYS, C_IN_VALID, C_CMD_SET, C_CMD_TICK, C_CMD_LIST, C_I_END,
        C_TAG_HIT, C_AT_CAP, C_SLOT_EXP, C_OUT_FREE, C_CNT_ZERO
    } cond_t;

    typedef enum logic [1:0] { TS_ZERO, TS_IN, TS_SLOT } tag_src_t;
    typedef enum logic [1:0] { RS_ZERO, RS_IN, RS_SLOT } rem_src_t;
    typedef enum logic       { AS_COUNT, AS_LEFT } act_src_t;
    typedef enum logic [1:0] { LS_ONE, LS_EXP, LS_LIST } last_src_t;

    typedef struct packed {
        step_t     jt;
        step_t     jf;
        cond_t     cond;
        logic      take;       // input ready, latch item on transfer
        logic      clr_i;
        logic      clr_cnt;    // clear w, expired and emitted counters
        logic      inc_i;
        logic      inc_w;
        logic      inc_e;
        logic      count_exp;  // pre-pass: count expiring slots
        logic      wr_upd;
        logic      wr_new;
        logic      wr_keep;
        logic      set_count_w;
        logic      emit;
        kind_t     kind;
        tag_src_t  tag_src;
        rem_src_t  rem_src;
        act_src_t  act_src;
        last_src_t last_src;
    } cw_t;

    typedef struct packed {
        logic in_valid;
        logic is_set;
        logic is_tick;
        logic is_list;
        logic i_end;
        logic tag_hit;
        logic at_cap;
        logic slot_exp;
        logic out_free;
        logic cnt_zero;
    } flags_t;

    function automatic cw_t ucode(input step_t st);
        cw_t w;
        w = '0;
        w.jt = ST_IDLE;
        w.jf = ST_IDLE;
        w.cond = C_ALWAYS;
        w.kind = KIND_CREATED;
        w.tag_src = TS_ZERO;
        w.rem_src = RS_ZERO;
        w.act_src = AS_COUNT;
        w.last_src = LS_ONE;
        unique case (st)
            ST_IDLE: begin
                w.cond = C_IN_VALID; w.jt = ST_DSP0; w.jf = ST_IDLE;
                w.take = 1'b1; w.clr_i = 1'b1; w.clr_cnt = 1'b1;
            end
            ST_DSP0: begin
                w.cond = C_CMD_SET; w.jt = ST_SSCAN; w.jf = ST_DSP1;
            end
            ST_DSP1: begin
                w.cond = C_CMD_TICK; w.jt = ST_TCNT; w.jf = ST_DSP2;
            end
            ST_DSP2: begin
                w.cond = C_CMD_LIST; w.jt = ST_LCHK; w.jf = ST_IDLE;
            end
            ST_SSCAN: begin
                w.cond = C_I_END; w.jt = ST_SCAP; w.jf = ST_SCMP;
            end
            ST_SCMP: begin
                w.cond = C_TAG_HIT; w.jt = ST_SUPD; w.jf = ST_SNEXT;
            end
            ST_SNEXT: begin
                w.jt = ST_SSCAN; w.inc_i = 1'b1;
            end
            ST_SUPD: begin
                w.cond = C_OUT_FREE; w.jt = ST_IDLE; w.jf = ST_SUPD;
                w.wr_upd = 1'b1; w.emit = 1'b1; w.kind = KIND_UPDATED;
                w.tag_src = TS_IN; w.rem_src = RS_IN;
            end
            ST_SCAP: begin
                w.cond = C_AT_CAP; w.jt = ST_SFULL; w.jf = ST_SNEW;
            end
            ST_SNEW: begin
                w.jt = ST_SCRE; w.wr_new = 1'b1;
            end
            ST_SCRE: begin
                w.cond = C_OUT_FREE; w.jt = ST_IDLE; w.jf = ST_SCRE;
                w.emit = 1'b1; w.kind = KIND_CREATED;
                w.tag_src = TS_IN; w.rem_src = RS_IN;
            end
            ST_SFULL: begin
                w.cond = C_OUT_FREE; w.jt = ST_IDLE; w.jf = ST_SFULL;
                w.emit = 1'b1; w.kind = KIND_FULL; w.tag_src = TS_IN;
            end
            ST_TCNT: begin
                w.cond = C_I_END; w.jt = ST_TPREP; w.jf = ST_TCNT;
                w.count_exp = 1'b1;
            end
            ST_TPREP: begin
                w.jt = ST_TWALK; w.clr_i = 1'b1;
            end
            ST_TWALK: begin
                w.cond = C_I_END; w.jt = ST_TFIN; w.jf = ST_TSLOT;
            end
            ST_TSLOT: begin
                w.cond = C_SLOT_EXP; w.jt = ST_TEXP; w.jf = ST_TKEEP;
            end
            ST_TKEEP: begin
                w.jt = ST_TWALK; w.wr_keep = 1'b1; w.inc_i = 1'b1; w.inc_w = 1'b1;
            end
            ST_TEXP: begin
                w.cond = C_OUT_FREE; w.jt = ST_TWALK; w.jf = ST_TEXP;
                w.emit = 1'b1; w.kind = KIND_EXPIRED; w.tag_src = TS_SLOT;
                w.act_src = AS_LEFT; w.last_src = LS_EXP;
                w.inc_i = 1'b1; w.inc_e = 1'b1;
            end
            ST_TFIN: begin
                w.jt = ST_IDLE; w.set_count_w = 1'b1;
            end
            ST_LCHK: begin
                w.cond = C_CNT_ZERO; w.jt = ST_LEMPTY; w.jf = ST_LENT;
            end
            ST_LEMPTY: begin
                w.cond = C_OUT_FREE; w.jt = ST_IDLE; w.jf = ST_LEMPTY;
                w.emit = 1'b1; w.kind = KIND_EMPTY;
            end
            ST_LENT: begin
                w.cond = C_OUT_FREE; w.jt = ST_LNXT; w.jf = ST_LENT;
                w.emit = 1'b1; w.kind = KIND_ENTRY; w.tag_src = TS_SLOT;
                w.rem_src = RS_SLOT; w.last_src = LS_LIST; w.inc_i = 1'b1;
            end
            ST_LNXT: begin
                w.cond = C_I_END; w.jt = ST_IDLE; w.jf = ST_LENT;
            end
            default: begin
                w.jt = ST_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

/* sv/tagged_countdown_timer_bank.sv */
// Top level of the tagged countdown timer bank: slot storage, counters, output register.
// Depends on tctb_pkg and tctb_seq.
//
// Usage:
//   Input stream s_*: one command per transfer. s_tuser carries the command (set, tick,
//   list), s_tdata the tag and the seconds of a set command. Results leave on m_*:
//   m_tuser is the result kind, m_tdata tag / remaining seconds / active count, and
//   m_tlast marks the final result of a command. A tick with nothing expiring and the
//   unused command code give no result. The capacity register, written through cfg_we /
//   cfg_wdata, is to be written by the user only while idle; the block does not enforce it.
// Sequencing:
//   A microcoded sequencer walks the slots one at a time through one read port.
// Reset: no timers active, capacity 1, output empty.
// Stall: a result waits in the output register; the sequencer holds on the next result
//   until the register frees, so no result is lost. Input is taken only when idle.
`default_nettype none

module tagged_countdown_timer_bank (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output      logic        s_tready,
    input  wire logic [31:0] s_tdata,   // [15:0] tag, [31:16] seconds
    input  wire logic [1:0]  s_tuser,   // [1:0] cmd
    output      logic        m_tvalid,
    input  wire logic        m_tready,
    output      logic [39:0] m_tdata,   // [15:0] timer_tag, [31:16] remaining, [35:32] active
    output      logic [2:0]  m_tuser,   // [2:0] kind
    output      logic        m_tlast,
    input  wire logic        cfg_we,
    input  wire logic [3:0]  cfg_wdata  // capacity
);
    import tctb_pkg::*;

    cw_t    cw;
    flags_t flags;

    logic [TAG_W-1:0] slot_tags_reg [SLOTS];
    logic [SEC_W-1:0] slot_secs_reg [SLOTS];

    logic [CNT_W-1:0] count_reg, i_reg, w_reg, nexp_reg, eseen_reg;
    logic [CAP_W-1:0] capacity_reg;
    logic [CMD_W-1:0] cmd_reg;
    logic [TAG_W-1:0] tag_reg;
    logic [SEC_W-1:0] secs_reg;

    logic             m_tvalid_reg;
    logic [39:0]      m_tdata_reg;
    logic [2:0]       m_tuser_reg;
    logic             m_tlast_reg;

    logic [TAG_W-1:0] rd_tag;
    logic [SEC_W-1:0] rd_sec;
    logic [CAP_W-1:0] cap_eff;
    logic             out_free, act_en, accept;
    logic [TAG_W-1:0] o_tag;
    logic [SEC_W-1:0] o_rem;
    logic [CNT_W-1:0] o_act;
    logic             o_last;

    tctb_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .flags   (flags),
        .cw      (cw)
    );

    assign rd_tag   = slot_tags_reg[i_reg[IDX_W-1:0]];
    assign rd_sec   = slot_secs_reg[i_reg[IDX_W-1:0]];
    assign cap_eff  = (capacity_reg > CAP_W'(SLOTS)) ? CAP_W'(SLOTS) : capacity_reg;
    assign out_free = !m_tvalid_reg || m_tready;
    // an emitting step does nothing until the output register can take its result
    assign act_en   = !cw.emit || out_free;
    assign s_tready = cw.take;
    assign accept   = s_tvalid && cw.take;

    always_comb begin
        flags.in_valid = s_tvalid;
        flags.is_set   = (cmd_reg == CMD_SET);
        flags.is_tick  = (cmd_reg == CMD_TICK);
        flags.is_list  = (cmd_reg == CMD_LIST);
        flags.i_end    = (i_reg >= count_reg);
        flags.tag_hit  = (rd_tag == tag_reg);
        flags.at_cap   = (CAP_W'(count_reg) >= cap_eff);
        flags.slot_exp = (rd_sec <= SEC_W'(1));
        flags.out_free = out_free;
        flags.cnt_zero = (count_reg == '0);
    end

    always_comb begin
        case (cw.tag_src)
            TS_IN:   o_tag = tag_reg;
            TS_SLOT: o_tag = rd_tag;
            default: o_tag = '0;
        endcase
        case (cw.rem_src)
            RS_IN:   o_rem = secs_reg;
            RS_SLOT: o_rem = rd_sec;
            default: o_rem = '0;
        endcase
        case (cw.act_src)
            AS_LEFT: o_act = count_reg - nexp_reg;
            default: o_act = count_reg;
        endcase
        case (cw.last_src)
            LS_EXP:  o_last = (eseen_reg == nexp_reg - CNT_W'(1));
            LS_LIST: o_last = (i_reg == count_reg - CNT_W'(1));
            default: o_last = 1'b1;
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= '0;
            i_reg        <= '0;
            w_reg        <= '0;
            nexp_reg     <= '0;
            eseen_reg    <= '0;
            capacity_reg <= CAP_W'(1);
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                capacity_reg <= cfg_wdata;
            end
            if (act_en) begin
                if (cw.clr_i) begin
                    i_reg <= '0;
                end else if (cw.inc_i || (cw.count_exp && !flags.i_end)) begin
                    i_reg <= i_reg + CNT_W'(1);
                end
                if (cw.clr_cnt) begin
                    w_reg     <= '0;
                    nexp_reg  <= '0;
                    eseen_reg <= '0;
                end else begin
                    if (cw.inc_w) begin
                        w_reg <= w_reg + CNT_W'(1);
                    end
                    if (cw.inc_e) begin
                        eseen_reg <= eseen_reg + CNT_W'(1);
                    end
                    if (cw.count_exp && !flags.i_end && flags.slot_exp) begin
                        nexp_reg <= nexp_reg + CNT_W'(1);
                    end
                end
                if (cw.wr_new) begin
                    count_reg <= count_reg + CNT_W'(1);
                end else if (cw.set_count_w) begin
                    count_reg <= w_reg;
                end
            end
            if (cw.emit && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // payload: latched command, slot storage, output data
    always_ff @(posedge aclk) begin
        if (accept) begin
            cmd_reg  <= s_tuser;
            tag_reg  <= s_tdata[15:0];
            secs_reg <= s_tdata[31:16];
        end
        if (act_en) begin
            if (cw.wr_upd) begin
                slot_secs_reg[i_reg[IDX_W-1:0]] <= secs_reg;
            end else if (cw.wr_new) begin
                slot_tags_reg[count_reg[IDX_W-1:0]] <= tag_reg;
                slot_secs_reg[count_reg[IDX_W-1:0]] <= secs_reg;
            end else if (cw.wr_keep) begin
                // compaction: w never passes i, so the move is safe in place
                slot_tags_reg[w_reg[IDX_W-1:0]] <= rd_tag;
                slot_secs_reg[w_reg[IDX_W-1:0]] <= rd_sec - SEC_W'(1);
            end
        end
        if (cw.emit && out_free) begin
            m_tdata_reg <= {4'b0, o_act, o_rem, o_tag};
            m_tuser_reg <= cw.kind;
            m_tlast_reg <= o_last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(SLOTS))
        else $error("active count above slot count");

    a_compact_order: assert property (@(posedge aclk) disable iff (!aresetn)
        cw.wr_keep |-> (w_reg <= i_reg))
        else $error("compaction write ahead of read pointer");

    a_emit_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && !m_tready) |=> $stable(m_tdata_reg) && m_tvalid_reg)
        else $error("stalled result changed");

endmodule

`default_nettype wire

/* sv/tctb_seq.sv */
// Microcode sequencer: step counter, condition select and jump logic.
// Control words come from tctb_pkg::ucode; flags come from the datapath.
`default_nettype none

module tctb_seq (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire tctb_pkg::flags_t flags,
    output tctb_pkg::cw_t        cw
);
    import tctb_pkg::*;

    step_t step_reg, step_next;
    logic  cond_true;

    assign cw = ucode(step_reg);

    always_comb begin
        case (cw.cond)
            C_ALWAYS:   cond_true = 1'b1;
            C_IN_VALID: cond_true = flags.in_valid;
            C_CMD_SET:  cond_true = flags.is_set;
            C_CMD_TICK: cond_true = flags.is_tick;
            C_CMD_LIST: cond_true = flags.is_list;
            C_I_END:    cond_true = flags.i_end;
            C_TAG_HIT:  cond_true = flags.tag_hit;
            C_AT_CAP:   cond_true = flags.at_cap;
            C_SLOT_EXP: cond_true = flags.slot_exp;
            C_OUT_FREE: cond_true = flags.out_free;
            C_CNT_ZERO: cond_true = flags.cnt_zero;
            default:    cond_true = 1'b1;
        endcase
        step_next = cond_true ? cw.jt : cw.jf;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= ST_IDLE;
        end else begin
            step_reg <= step_next;
        end
    end

    a_idle_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        (step_reg == ST_IDLE && !flags.in_valid) |=> step_reg == ST_IDLE)
        else $error("sequencer left idle without an input transfer");

    a_emit_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (cw.emit && !flags.out_free) |=> $stable(step_reg))
        else $error("sequencer advanced past a stalled result");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> step_reg == ST_IDLE)
        else $error("sequencer not idle after reset");

endmodule

`default_nettype wire
